// ===== hw/rtl/dhcp_message_parser_macros.svh =====
// ----------------------------------------------------------------------------
// DHCP message parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef DHCP_MESSAGE_PARSER_MACROS_SVH
`define DHCP_MESSAGE_PARSER_MACROS_SVH

// Check an implication on every clock edge out of reset.
`define DMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define DMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dmp_pkg.sv =====
// ----------------------------------------------------------------------------
// DHCP message parser package
// Types, constants and header layout shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmp_pkg;

  localparam int unsigned NUM_FIELDS   = 12;
  localparam int unsigned COOKIE_POS   = 236;
  localparam int unsigned LAST_HDR_POS = 239;
  localparam int unsigned HDR_LEN      = 240;
  localparam logic [7:0]  OPT_PAD      = 8'd0;
  localparam logic [7:0]  OPT_END      = 8'd255;
  localparam logic [7:0]  OPT_MSG_TYPE = 8'd53;

  typedef enum logic [1:0] {
    K_HDR       = 2'd0,
    K_OPT_START = 2'd1,
    K_OPT_DATA  = 2'd2,
    K_SUMMARY   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TRUNC      = 2'd1,
    ST_BAD_COOKIE = 2'd2
  } st_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_CODE    = 3'd1,
    PH_LEN     = 3'd2,
    PH_DATA    = 3'd3,
    PH_DONE    = 3'd4,
    PH_DISCARD = 3'd5
  } ph_e;

  typedef enum logic [1:0] {
    SQ_RUN = 2'd0,
    SQ_HDR = 2'd1,
    SQ_SUM = 2'd2
  } seq_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  field_id;
    logic [47:0] field_value;
    logic [7:0]  option_code;
    logic [7:0]  option_length;
    logic [7:0]  data_byte;
    logic        option_complete;
    st_e         status;
    logic [7:0]  message_type;
    logic        type_seen;
    logic        option_cut;
    logic        last;
  } res_t;

  typedef struct packed {
    st_e        status;
    logic [7:0] mtype;
    logic       seen;
    logic       cut;
  } sum_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [47:0] data;
  } hw_t;

  typedef struct packed {
    logic opt_valid;
    res_t opt;
    logic hdr_burst;
    sum_t sum;
  } step_t;

  typedef struct packed {
    logic       keep;
    logic [3:0] id;
    logic       first;
    logic       fin;
  } hf_t;

  function automatic hf_t hdr_field(logic [7:0] pos);
    hf_t        f;
    logic [7:0] rel;
    f   = '0;
    rel = pos - 8'd12;
    if (pos < 8'd4) begin
      f = '{keep: 1'b1, id: pos[3:0], first: 1'b1, fin: 1'b1};
    end else if (pos < 8'd8) begin
      f = '{keep: 1'b1, id: 4'd4, first: pos == 8'd4, fin: pos == 8'd7};
    end else if (pos < 8'd10) begin
      f = '{keep: 1'b1, id: 4'd5, first: pos == 8'd8, fin: pos == 8'd9};
    end else if (pos < 8'd12) begin
      f = '{keep: 1'b1, id: 4'd6, first: pos == 8'd10, fin: pos == 8'd11};
    end else if (pos < 8'd28) begin
      f = '{keep: 1'b1, id: 4'd7 + {2'b00, rel[3:2]},
            first: pos[1:0] == 2'd0, fin: pos[1:0] == 2'd3};
    end else if (pos < 8'd34) begin
      f = '{keep: 1'b1, id: 4'd11, first: pos == 8'd28, fin: pos == 8'd33};
    end
    return f;
  endfunction

  function automatic logic [7:0] cookie_byte(logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h63;
      2'd1:    c = 8'h82;
      2'd2:    c = 8'h53;
      default: c = 8'h63;
    endcase
    return c;
  endfunction

  function automatic res_t mk_summary(sum_t s);
    res_t r;
    r              = '0;
    r.kind         = K_SUMMARY;
    r.status       = s.status;
    r.message_type = s.mtype;
    r.type_seen    = s.seen;
    r.option_cut   = s.cut;
    r.last         = 1'b1;
    return r;
  endfunction

endpackage

// ===== hw/rtl/dmp_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// DHCP header field store
// Twelve 48-bit fields, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmp_hdr_ram import dmp_pkg::*; (
  input  logic        clk_i,
  input  hw_t         wr_i,
  input  logic [3:0]  raddr_i,
  output logic [47:0] rdata_o
);

  logic [47:0] mem_q [NUM_FIELDS];
  logic [47:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dmp_step.sv =====
// ----------------------------------------------------------------------------
// DHCP parse step
// Per-byte parse state: header gathering, cookie check, option walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmp_step import dmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_value_i,
  input  logic       is_last_i,
  output step_t      step_o,
  output hw_t        wr_o
);

  logic [7:0]  pos_q, pos_d;
  ph_e         phase_q, phase_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  remain_q, remain_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  ctype_q, ctype_d;
  logic        found_q, found_d;
  st_e         status_q, status_d;
  logic [39:0] acc_q, acc_d;
  hf_t         hf;
  logic [47:0] fval;
  logic [7:0]  rem_dec;
  logic        ok;

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    code_d   = code_q;
    remain_d = remain_q;
    len_d    = len_q;
    pend_d   = pend_q;
    ctype_d  = ctype_q;
    found_d  = found_q;
    status_d = status_q;
    acc_d    = acc_q;
    hf       = hdr_field(pos_q);
    fval     = hf.first ? {40'd0, byte_value_i} : {acc_q, byte_value_i};
    rem_dec  = remain_q - 8'd1;
    wr_o     = '0;
    step_o   = '0;
    step_o.opt.last = !is_last_i;

    unique case (phase_q)
      PH_HEADER: begin
        if (hf.keep) begin
          acc_d   = fval[39:0];
          wr_o.we = accept_i && hf.fin;
        end
        wr_o.addr = hf.id;
        wr_o.data = fval;
        if (pos_q >= 8'(COOKIE_POS) && pos_q <= 8'(LAST_HDR_POS)
            && byte_value_i != cookie_byte(pos_q[1:0])) begin
          status_d = ST_BAD_COOKIE;
        end
        if (pos_q == 8'(LAST_HDR_POS)) begin
          if (status_d == ST_OK) begin
            step_o.hdr_burst = 1'b1;
            phase_d          = PH_CODE;
          end else begin
            phase_d = PH_DISCARD;
          end
        end
        if (pos_q < 8'(HDR_LEN)) begin
          pos_d = pos_q + 8'd1;
        end
      end
      PH_CODE: begin
        if (byte_value_i == OPT_END) begin
          phase_d = PH_DONE;
        end else if (byte_value_i != OPT_PAD) begin
          code_d  = byte_value_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        len_d                       = byte_value_i;
        remain_d                    = byte_value_i;
        step_o.opt_valid            = 1'b1;
        step_o.opt.kind             = K_OPT_START;
        step_o.opt.option_code      = code_q;
        step_o.opt.option_length    = byte_value_i;
        step_o.opt.option_complete  = byte_value_i == 8'd0;
        phase_d = (byte_value_i == 8'd0) ? PH_CODE : PH_DATA;
      end
      PH_DATA: begin
        if (remain_q == len_q && code_q == OPT_MSG_TYPE) begin
          pend_d = byte_value_i;
        end
        remain_d                    = rem_dec;
        step_o.opt_valid            = 1'b1;
        step_o.opt.kind             = K_OPT_DATA;
        step_o.opt.option_code      = code_q;
        step_o.opt.option_length    = len_q;
        step_o.opt.data_byte        = byte_value_i;
        step_o.opt.option_complete  = rem_dec == 8'd0;
        if (rem_dec == 8'd0) begin
          if (code_q == OPT_MSG_TYPE) begin
            ctype_d = pend_d;
            found_d = 1'b1;
          end
          phase_d = PH_CODE;
        end
      end
      default: begin
      end
    endcase

    step_o.sum.status = (phase_d == PH_HEADER) ? ST_TRUNC : status_d;
    ok                = step_o.sum.status == ST_OK;
    step_o.sum.mtype  = ok ? ctype_d : 8'd0;
    step_o.sum.seen   = ok && found_d;
    step_o.sum.cut    = ok && (phase_d == PH_LEN || phase_d == PH_DATA);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_HEADER;
      code_q   <= '0;
      remain_q <= '0;
      len_q    <= '0;
      pend_q   <= '0;
      ctype_q  <= '0;
      found_q  <= 1'b0;
      status_q <= ST_OK;
    end else if (accept_i) begin
      if (is_last_i) begin
        pos_q    <= '0;
        phase_q  <= PH_HEADER;
        code_q   <= '0;
        remain_q <= '0;
        len_q    <= '0;
        pend_q   <= '0;
        ctype_q  <= '0;
        found_q  <= 1'b0;
        status_q <= ST_OK;
      end else begin
        pos_q    <= pos_d;
        phase_q  <= phase_d;
        code_q   <= code_d;
        remain_q <= remain_d;
        len_q    <= len_d;
        pend_q   <= pend_d;
        ctype_q  <= ctype_d;
        found_q  <= found_d;
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== hw/rtl/dhcp_message_parser.sv =====
// A DHCP message enters one byte per cycle, first byte first, with is_last_i
// on its final byte, while the input is not stalled. The input stalls while
// a held output word is stalled by out_stall_i; after the last cookie byte
// of a message with a good cookie, while the twelve header fields are read
// out of the header store one per cycle unless the output stalls (and the
// summary word is sent when that byte is also the last); and after a final
// byte that both yields an option result and ends the message, while the
// summary word is sent. The header store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
// DHCP message parser
// Byte-stream DHCP/BOOTP parser: header fields, cookie check, option walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dhcp_message_parser_macros.svh"

module dhcp_message_parser import dmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  field_id_o,
  output logic [47:0] field_value_o,
  output logic [7:0]  option_code_o,
  output logic [7:0]  option_length_o,
  output logic [7:0]  data_byte_o,
  output logic        option_complete_o,
  output logic [1:0]  status_o,
  output logic [7:0]  message_type_o,
  output logic        type_seen_o,
  output logic        option_cut_o,
  output logic        last_o
);

  seq_e        seq_q, seq_d;
  logic [3:0]  idx_q, idx_d;
  logic        sum_pend_q, sum_pend_d;
  sum_t        sum_q, sum_d;
  logic        out_valid_q, out_valid_d;
  res_t        out_q, out_d;
  logic        out_free;
  logic        accept;
  logic [3:0]  idx_nx;
  logic [3:0]  raddr;
  logic [47:0] rdata;
  step_t       step;
  hw_t         wr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (seq_q != SQ_RUN) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_nx     = (idx_q == 4'(NUM_FIELDS - 1)) ? 4'd0 : idx_q + 4'd1;
  assign raddr      = (seq_q == SQ_HDR && out_free) ? idx_nx : idx_q;

  dmp_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_value_i(byte_value_i),
    .is_last_i   (is_last_i),
    .step_o      (step),
    .wr_o        (wr)
  );

  dmp_hdr_ram u_hdr_ram (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    seq_d       = seq_q;
    idx_d       = idx_q;
    sum_pend_d  = sum_pend_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (seq_q)
      SQ_RUN: begin
        if (accept) begin
          if (step.hdr_burst) begin
            seq_d      = SQ_HDR;
            idx_d      = '0;
            sum_pend_d = is_last_i;
            sum_d      = step.sum;
          end else if (step.opt_valid) begin
            out_valid_d = 1'b1;
            out_d       = step.opt;
            if (is_last_i) begin
              seq_d = SQ_SUM;
              sum_d = step.sum;
            end
          end else if (is_last_i) begin
            out_valid_d = 1'b1;
            out_d       = mk_summary(step.sum);
          end
        end
      end
      SQ_HDR: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.kind        = K_HDR;
          out_d.field_id    = idx_q;
          out_d.field_value = rdata;
          out_d.last        = (idx_q == 4'(NUM_FIELDS - 1)) && !sum_pend_q;
          idx_d             = idx_nx;
          if (idx_q == 4'(NUM_FIELDS - 1)) begin
            seq_d = sum_pend_q ? SQ_SUM : SQ_RUN;
          end
        end
      end
      SQ_SUM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = mk_summary(sum_q);
          seq_d       = SQ_RUN;
        end
      end
      default: begin
        seq_d = SQ_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_RUN;
      idx_q       <= '0;
      sum_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      idx_q       <= idx_d;
      sum_pend_q  <= sum_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    out_q <= out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign field_id_o        = out_q.field_id;
  assign field_value_o     = out_q.field_value;
  assign option_code_o     = out_q.option_code;
  assign option_length_o   = out_q.option_length;
  assign data_byte_o       = out_q.data_byte;
  assign option_complete_o = out_q.option_complete;
  assign status_o          = out_q.status;
  assign message_type_o    = out_q.message_type;
  assign type_seen_o       = out_q.type_seen;
  assign option_cut_o      = out_q.option_cut;
  assign last_o            = out_q.last;

  `DMP_ASSERT(a_wr_only_run, wr.we |-> seq_q == SQ_RUN, "header write outside run")
  `DMP_ASSERT(a_idx_idle, seq_q != SQ_HDR |-> idx_q == 4'd0, "field index left set")
  `DMP_ASSERT(a_sum_after_word, seq_q == SQ_SUM |-> out_valid_q, "summary without prior word")
  `DMP_ASSERT_NEXT(a_hdr_word, seq_q == SQ_HDR && out_free,
    out_valid_q && out_q.kind == K_HDR && out_q.field_id == $past(idx_q),
    "header word out of order")

endmodule
